/* hw/rtl/int_to_radix_symbols_core_defines.svh */
// Assertion macros shared by the RTL of the radix symbol converter.
// Both macros sample on the rising edge of clock and are disabled while reset is high.
// Defining NO_ASSERTIONS turns every use into empty text.
`ifndef INT_TO_RADIX_SYMBOLS_CORE_DEFINES_SVH
`define INT_TO_RADIX_SYMBOLS_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication: whenever ante holds, cons holds too.
`define ITRS_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication: whenever ante holds, cons holds in the following cycle.
`define ITRS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`else

`define ITRS_ASSERT_IMPLY(label, ante, cons, msg)
`define ITRS_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

/* hw/rtl/itrs_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package itrs_pkg;

   localparam int VALUE_W      = 32;
   localparam int SYM_W        = 8;
   localparam int LEN_W        = 5;
   localparam int NUM_SYMBOLS  = 16;
   localparam int SYM_IDX_W    = 4;
   localparam int SYMS_W       = NUM_SYMBOLS * SYM_W;
   localparam int DIGITS_MAX   = 32;
   localparam int DIGIT_IDX_W  = 5;
   localparam int CSR_IDX_W    = 2;
   localparam int CSR_DATA_W   = 64;
   localparam int MAX_RADIX_DEF = 16;

   localparam logic [SYM_W-1:0] MINUS_SYM = 8'h2D;
   localparam logic [SYM_W-1:0] PLUS_SYM  = 8'h2B;

   localparam logic [CSR_IDX_W-1:0] CSR_ALPHABET_LENGTH = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SYMBOLS_LOW     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SYMBOLS_HIGH    = 2'd2;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;       // capture a new request
      logic mul;        // reciprocal multiply of the running quotient
      logic fix;        // remainder correction, store one digit
      logic step;       // move to the next stored digit
      logic show_sign;  // present the minus sign on the response
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic alpha_ok;    // configured alphabet is usable
      logic negative;    // captured value was negative
      logic quot_zero;   // quotient after this digit is zero
      logic last_digit;  // read pointer sits on the least significant digit
   } ctrl_status_type;

   // floor(2^32 / radix). The estimate (n * recip) >> 32 is the true quotient
   // or one below it, which a single remainder compare fixes.
   function automatic logic [VALUE_W-1:0] recip_of(input logic [LEN_W-1:0] radix);
      logic [VALUE_W-1:0] r;
      begin
         unique case (radix)
            5'd2:    r = 32'h8000_0000;
            5'd3:    r = 32'h5555_5555;
            5'd4:    r = 32'h4000_0000;
            5'd5:    r = 32'h3333_3333;
            5'd6:    r = 32'h2AAA_AAAA;
            5'd7:    r = 32'h2492_4924;
            5'd8:    r = 32'h2000_0000;
            5'd9:    r = 32'h1C71_C71C;
            5'd10:   r = 32'h1999_9999;
            5'd11:   r = 32'h1745_D174;
            5'd12:   r = 32'h1555_5555;
            5'd13:   r = 32'h13B1_3B13;
            5'd14:   r = 32'h1249_2492;
            5'd15:   r = 32'h1111_1111;
            5'd16:   r = 32'h1000_0000;
            default: r = '0;
         endcase
         return r;
      end
   endfunction

endpackage

`default_nettype wire

/* hw/rtl/itrs_alpha_check.sv */
`timescale 1ns / 1ps
`default_nettype none

// Flags an alphabet that is too short, too long, holds a sign character
// or repeats a symbol among its used entries.
module itrs_alpha_check #(
   parameter int MAX_RADIX = itrs_pkg::MAX_RADIX_DEF
) (
   input  logic [itrs_pkg::LEN_W-1:0]  alphabet_length,
   input  logic [itrs_pkg::SYMS_W-1:0] symbols,
   output logic                        alpha_ok
);

   localparam int LEN_W = itrs_pkg::LEN_W;
   localparam int NSYM  = itrs_pkg::NUM_SYMBOLS;
   localparam int SYM_W = itrs_pkg::SYM_W;

   logic [NSYM-1:0] in_use;
   logic            len_ok;
   logic            has_sign;
   logic            has_dup;

   assign len_ok = (alphabet_length >= LEN_W'(2)) && (alphabet_length <= LEN_W'(MAX_RADIX));

   always_comb begin
      in_use   = '0;
      has_sign = 1'b0;
      has_dup  = 1'b0;
      for (int i = 0; i < NSYM; i++) begin
         in_use[i] = LEN_W'(i) < alphabet_length;
      end
      for (int i = 0; i < NSYM; i++) begin
         if (in_use[i] && ((symbols[i*SYM_W +: SYM_W] == itrs_pkg::PLUS_SYM) ||
                           (symbols[i*SYM_W +: SYM_W] == itrs_pkg::MINUS_SYM))) begin
            has_sign = 1'b1;
         end
         for (int j = i + 1; j < NSYM; j++) begin
            // A used entry j implies entry i is used as well.
            if (in_use[j] && (symbols[i*SYM_W +: SYM_W] == symbols[j*SYM_W +: SYM_W])) begin
               has_dup = 1'b1;
            end
         end
      end
   end

   assign alpha_ok = len_ok && !has_sign && !has_dup;

endmodule

`default_nettype wire

/* hw/rtl/itrs_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

// Sequencer: capture, divide loop (multiply then fix per digit), optional
// sign, then one character per accepted response.
module itrs_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  itrs_pkg::ctrl_status_type status,
   output itrs_pkg::ctrl_cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_FIX,
      ST_SIGN,
      ST_EMIT
   } state_type;

   state_type state_ff, state_in;
   logic      req_ready_ff;
   logic      rsp_valid_ff;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_ready_ff) begin
               cmd.load = 1'b1;
               // A bad alphabet drops the request without any response.
               if (status.alpha_ok) begin
                  state_in = ST_MUL;
               end
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_FIX;
         end
         ST_FIX: begin
            cmd.fix = 1'b1;
            if (status.quot_zero) begin
               state_in = status.negative ? ST_SIGN : ST_EMIT;
            end else begin
               state_in = ST_MUL;
            end
         end
         ST_SIGN: begin
            cmd.show_sign = 1'b1;
            if (rsp_ready) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (rsp_ready) begin
               cmd.step = 1'b1;
               if (status.last_digit) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         req_ready_ff <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         req_ready_ff <= (state_in == ST_IDLE);
         rsp_valid_ff <= (state_in == ST_SIGN) || (state_in == ST_EMIT);
      end
   end

   assign req_ready = req_ready_ff;
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

/* hw/rtl/itrs_dpath.sv */
`timescale 1ns / 1ps
`default_nettype none

// Magnitude, reciprocal divider step, digit store and character select.
module itrs_dpath #(
   parameter int MAX_RADIX = itrs_pkg::MAX_RADIX_DEF
) (
   input  logic                               clock,
   input  itrs_pkg::ctrl_cmd_type             cmd,
   output itrs_pkg::ctrl_status_type          status,
   input  logic signed [itrs_pkg::VALUE_W-1:0] value,
   input  logic [itrs_pkg::LEN_W-1:0]         alphabet_length,
   input  logic [itrs_pkg::SYMS_W-1:0]        symbols,
   output logic [itrs_pkg::SYM_W-1:0]         symbol,
   output logic                               final_symbol
);

   localparam int VALUE_W   = itrs_pkg::VALUE_W;
   localparam int SYM_W     = itrs_pkg::SYM_W;
   localparam int SYM_IDX_W = itrs_pkg::SYM_IDX_W;
   localparam int IDX_W     = itrs_pkg::DIGIT_IDX_W;
   localparam int DIGIT_W   = $clog2(MAX_RADIX);
   // The corrected remainder stays below twice the radix.
   localparam int REM_W     = DIGIT_W + 1;

   logic [VALUE_W-1:0]   raw;
   logic [VALUE_W-1:0]   value_mag;
   logic [VALUE_W-1:0]   mag_ff;
   logic                 neg_ff;
   logic [REM_W-1:0]     radix_ff;
   logic [VALUE_W-1:0]   recip_ff;
   logic [VALUE_W-1:0]   qest_ff;
   logic [DIGIT_W-1:0]   digits_ff [itrs_pkg::DIGITS_MAX];
   logic [IDX_W-1:0]     wr_idx_ff;
   logic [IDX_W-1:0]     rd_idx_ff;

   logic [2*VALUE_W-1:0] product;
   logic [2*REM_W-1:0]   qr_low;
   logic [REM_W-1:0]     rem;
   logic                 rem_ge;
   logic [REM_W-1:0]     digit_full;
   logic [VALUE_W-1:0]   q_next;
   logic [SYM_IDX_W-1:0] sym_idx;

   assign raw       = value;
   assign value_mag = raw[VALUE_W-1] ? (~raw + VALUE_W'(1)) : raw;

   assign product = mag_ff * recip_ff;

   // Only the low bits of n - q*r matter, since the true difference is
   // below twice the radix.
   assign qr_low     = qest_ff[REM_W-1:0] * radix_ff;
   assign rem        = mag_ff[REM_W-1:0] - qr_low[REM_W-1:0];
   assign rem_ge     = rem >= radix_ff;
   assign digit_full = rem_ge ? (rem - radix_ff) : rem;
   assign q_next     = rem_ge ? (qest_ff + VALUE_W'(1)) : qest_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mag_ff    <= value_mag;
         neg_ff    <= raw[VALUE_W-1];
         radix_ff  <= REM_W'(alphabet_length);
         recip_ff  <= itrs_pkg::recip_of(alphabet_length);
         wr_idx_ff <= '0;
      end
      if (cmd.mul) begin
         qest_ff <= product[2*VALUE_W-1:VALUE_W];
      end
      if (cmd.fix) begin
         digits_ff[wr_idx_ff] <= digit_full[DIGIT_W-1:0];
         rd_idx_ff            <= wr_idx_ff;
         wr_idx_ff            <= wr_idx_ff + IDX_W'(1);
         mag_ff               <= q_next;
      end
      if (cmd.step) begin
         rd_idx_ff <= rd_idx_ff - IDX_W'(1);
      end
   end

   itrs_alpha_check #(
      .MAX_RADIX(MAX_RADIX)
   ) u_alpha_check (
      .alphabet_length(alphabet_length),
      .symbols        (symbols),
      .alpha_ok       (status.alpha_ok)
   );

   assign status.negative   = neg_ff;
   assign status.quot_zero  = (q_next == '0);
   assign status.last_digit = (rd_idx_ff == '0);

   assign sym_idx      = SYM_IDX_W'(digits_ff[rd_idx_ff]);
   assign symbol       = cmd.show_sign ? itrs_pkg::MINUS_SYM : symbols[sym_idx*SYM_W +: SYM_W];
   assign final_symbol = !cmd.show_sign && status.last_digit;

endmodule

`default_nettype wire

/* hw/rtl/int_to_radix_symbols_core.sv */
// Channel   Direction  Handshake              Payload
// req       in         req_valid / req_ready  req_value (signed 32)
// rsp       out        rsp_valid / rsp_ready  rsp_symbol (8), rsp_final_symbol (1)
// csr       in         csr_valid / csr_ready  csr_index (2), csr_data (64)
//
// A request is captured, then runs the divider loop for each digit (a 32x32 reciprocal
// multiply, then a remainder fix), then gives the minus sign if it is negative and the
// digits at one character per cycle while rsp_ready is high.
// Reset is synchronous and needs no clearing pass; configuration resets to zero.
// A stalled response holds its character; the next request is taken after the final one.
`timescale 1ns / 1ps
`default_nettype none
`include "int_to_radix_symbols_core_defines.svh"

module int_to_radix_symbols_core #(
   parameter int MAX_RADIX = itrs_pkg::MAX_RADIX_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // Request channel.
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [itrs_pkg::VALUE_W-1:0]  req_value,
   // Response channel.
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [itrs_pkg::SYM_W-1:0]           rsp_symbol,
   output logic                                 rsp_final_symbol,
   // Configuration write channel.
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [itrs_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [itrs_pkg::CSR_DATA_W-1:0]      csr_data
);

   localparam int LEN_W  = itrs_pkg::LEN_W;
   localparam int HALF_W = itrs_pkg::SYMS_W / 2;

   // Configuration registers. The alphabet is checked combinationally
   // whenever a request is captured, so a write takes effect at once.
   logic [LEN_W-1:0]  alphabet_length_ff;
   logic [HALF_W-1:0] symbols_low_ff;
   logic [HALF_W-1:0] symbols_high_ff;

   itrs_pkg::ctrl_cmd_type    cmd;
   itrs_pkg::ctrl_status_type status;

   // Writes are always accepted; an index past the register list is dropped.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         alphabet_length_ff <= '0;
         symbols_low_ff     <= '0;
         symbols_high_ff    <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            itrs_pkg::CSR_ALPHABET_LENGTH: begin
               alphabet_length_ff <= csr_data[LEN_W-1:0];
            end
            itrs_pkg::CSR_SYMBOLS_LOW: begin
               symbols_low_ff <= csr_data[HALF_W-1:0];
            end
            itrs_pkg::CSR_SYMBOLS_HIGH: begin
               symbols_high_ff <= csr_data[HALF_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // The controller sequences capture, the divider loop and the character
   // output; the datapath does the arithmetic and holds the digits.
   itrs_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .status   (status),
      .cmd      (cmd)
   );

   itrs_dpath #(
      .MAX_RADIX(MAX_RADIX)
   ) u_dpath (
      .clock          (clock),
      .cmd            (cmd),
      .status         (status),
      .value          (req_value),
      .alphabet_length(alphabet_length_ff),
      .symbols        ({symbols_high_ff, symbols_low_ff}),
      .symbol         (rsp_symbol),
      .final_symbol   (rsp_final_symbol)
   );

   // The block is either taking a request or delivering characters, never both.
   `ITRS_ASSERT_IMPLY(a_ready_excludes_valid, req_ready, !rsp_valid, "ready while response valid")

   // A request against a bad alphabet must leave no response behind.
   `ITRS_ASSERT_NEXT(a_bad_alpha_drops, req_valid && req_ready && !status.alpha_ok, req_ready && !rsp_valid, "bad alphabet produced a response")

   // The minus sign never closes a value's text.
   `ITRS_ASSERT_IMPLY(a_final_not_sign, rsp_valid && rsp_final_symbol, rsp_symbol != itrs_pkg::MINUS_SYM, "final character is the sign")

   // Once the final character is taken, the block is ready for a new request.
   `ITRS_ASSERT_NEXT(a_final_frees_input, rsp_valid && rsp_ready && rsp_final_symbol, req_ready, "not ready after final character")

endmodule

`default_nettype wire

/* dv/int_to_radix_symbols_core_tb.sv */
`timescale 1ns / 1ps

// The testbench drives signed integers into the radix converter and checks every character
// that comes back, in order, against its own model of the conversion. A short scripted
// table comes first. It covers an empty alphabet, the decimal and hexadecimal extremes,
// binary at full length, an ignored register index, and a length written with stray upper
// bits. It also covers each way an alphabet can be rejected and an alphabet holding a zero
// byte. Random phases follow with fresh alphabets. The sender idles and the receiver stalls
// in different mixes across these phases. The run ends with a long receiver hold-off that
// backs the block up into its request channel.
module int_to_radix_symbols_core_tb;

   localparam int CLOCK_HALF   = 2;
   localparam int RESET_CYCLES = 11;
   // The drain wait is sized for the slowest request (radix 2, full width), so it covers a
   // request that is still being worked on when it produces nothing.
   localparam int DRAIN_CYCLES = 120;
   localparam int HOLD_CYCLES  = 400;
   localparam int TIMEOUT_NS   = 4_000_000;
   localparam int LEN_W        = itrs_pkg::LEN_W;

   // Index 3 is not mapped to any register, and a write there must change nothing.
   localparam logic [itrs_pkg::CSR_IDX_W-1:0] CSR_UNMAPPED = 2'd3;

   typedef struct packed {
      logic [itrs_pkg::SYM_W-1:0] glyph;
      logic                       last;
   } glyph_type;

   typedef enum logic {ROW_CSR, ROW_VALUE} row_kind_type;

   typedef struct packed {
      row_kind_type                       kind;
      logic [itrs_pkg::CSR_IDX_W-1:0]     idx;
      logic [itrs_pkg::CSR_DATA_W-1:0]    data;
      logic [itrs_pkg::VALUE_W-1:0]       value;
      logic                               typed;
   } plan_row_type;

   typedef enum int {FLAW_LENGTH, FLAW_MINUS, FLAW_PLUS, FLAW_REPEAT} flaw_type;

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                req_valid = 1'b0;
   logic                                req_ready;
   logic signed [itrs_pkg::VALUE_W-1:0] req_value = '0;
   logic                                rsp_valid;
   logic                                rsp_ready = 1'b0;
   logic [itrs_pkg::SYM_W-1:0]          rsp_symbol;
   logic                                rsp_final_symbol;
   logic                                csr_valid = 1'b0;
   logic                                csr_ready;
   logic [itrs_pkg::CSR_IDX_W-1:0]      csr_index = '0;
   logic [itrs_pkg::CSR_DATA_W-1:0]     csr_data = '0;

   // This is the testbench's copy of the configuration, updated on each accepted write.
   logic [itrs_pkg::LEN_W-1:0]          cfg_len = '0;
   logic [itrs_pkg::SYMS_W-1:0]         cfg_syms = '0;

   // These are the characters still owed by the block, oldest first.
   glyph_type                           symbols_due[$];
   glyph_type                           glyph_want;

   plan_row_type                        plan[$];
   string                               plan_text[$];

   int                                  send_idle_pct = 0;
   int                                  recv_stall_pct = 0;
   int                                  hold_asked = 0;
   int                                  hold_seen = 0;
   int                                  hold_left = 0;
   int                                  mismatches = 0;
   int                                  values_sent = 0;
   int                                  glyphs_checked = 0;
   int                                  csr_writes = 0;

   int_to_radix_symbols_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_value        (req_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_symbol       (rsp_symbol),
      .rsp_final_symbol (rsp_final_symbol),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always begin
      #(CLOCK_HALF) clock = 1'b1;
      #(CLOCK_HALF) clock = 1'b0;
   end

   // Symbol i of the alphabet sits in byte i of the two concatenated symbol registers.
   function automatic logic [itrs_pkg::SYM_W-1:0] digit_glyph(input int idx);
      return cfg_syms[idx*8 +: 8];
   endfunction

   // An alphabet is usable when it holds 2 to MAX_RADIX symbols, none of them a sign and
   // none repeated. Bytes beyond the length do not matter.
   function automatic bit alphabet_usable();
      int n;
      int i;
      int j;
      logic [itrs_pkg::SYM_W-1:0] s;
      n = int'(cfg_len);
      if (n < 2 || n > itrs_pkg::MAX_RADIX_DEF) return 1'b0;
      for (i = 0; i < n; i++) begin
         s = digit_glyph(i);
         if (s == itrs_pkg::PLUS_SYM || s == itrs_pkg::MINUS_SYM) return 1'b0;
         for (j = i + 1; j < n; j++) begin
            if (digit_glyph(j) == s) return 1'b0;
         end
      end
      return 1'b1;
   endfunction

   // This function queues the text that the block should produce for one request. A
   // negative value is printed from its unsigned magnitude, so the most negative value
   // comes out right.
   function automatic void spell_value(input logic [itrs_pkg::VALUE_W-1:0] raw);
      logic [31:0] mag;
      logic [31:0] radix;
      logic [31:0] digits[32];
      int          nd;
      int          k;
      if (!alphabet_usable()) return;
      radix = 32'(cfg_len);
      mag = raw[31] ? (~raw + 32'd1) : raw;
      nd = 0;
      do begin
         digits[nd] = mag % radix;
         mag = mag / radix;
         nd++;
      end while (mag != 0 && nd < itrs_pkg::DIGITS_MAX);
      if (raw[31]) symbols_due.push_back(glyph_type'{itrs_pkg::MINUS_SYM, 1'b0});
      for (k = nd - 1; k >= 0; k--) begin
         symbols_due.push_back(glyph_type'{digit_glyph(digits[k]), k == 0});
      end
   endfunction

   // A configuration write happens only once the block has gone quiet. To get there, the
   // request channel is released, the owed text is allowed to drain, and a request that
   // produces nothing is given time to finish.
   task automatic write_csr(input logic [itrs_pkg::CSR_IDX_W-1:0] idx,
                            input logic [itrs_pkg::CSR_DATA_W-1:0] data);
      req_valid <= 1'b0;
      while (symbols_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         itrs_pkg::CSR_ALPHABET_LENGTH: cfg_len = data[itrs_pkg::LEN_W-1:0];
         itrs_pkg::CSR_SYMBOLS_LOW:     cfg_syms[63:0] = data;
         itrs_pkg::CSR_SYMBOLS_HIGH:    cfg_syms[127:64] = data;
         default: ;
      endcase
      csr_writes++;
      csr_valid <= 1'b0;
   endtask

   // One request is offered after a random gap. Valid is left high after acceptance, so a
   // back-to-back request only changes the payload within the same step.
   task automatic send_value(input logic [itrs_pkg::VALUE_W-1:0] v, input bit typed,
                             input string text);
      int gap;
      int k;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_value <= v;
      do @(posedge clock); while (!req_ready);
      if (typed) begin
         for (k = 0; k < text.len(); k++) begin
            symbols_due.push_back(glyph_type'{text[k], k == text.len() - 1});
         end
      end else begin
         spell_value(v);
      end
      values_sent++;
   endtask

   task automatic plan_csr(input logic [itrs_pkg::CSR_IDX_W-1:0] idx,
                           input logic [itrs_pkg::CSR_DATA_W-1:0] data);
      plan.push_back(plan_row_type'{ROW_CSR, idx, data, 32'd0, 1'b0});
      plan_text.push_back("");
   endtask

   task automatic plan_value(input logic [itrs_pkg::VALUE_W-1:0] v, input bit typed,
                             input string text);
      plan.push_back(plan_row_type'{ROW_VALUE, CSR_UNMAPPED, 64'd0, v, typed});
      plan_text.push_back(text);
   endtask

   // This function returns sixteen distinct random bytes, none of which is a sign.
   function automatic logic [itrs_pkg::SYMS_W-1:0] random_glyphs();
      bit                         used[256];
      logic [itrs_pkg::SYMS_W-1:0] syms;
      int                         k;
      int                         b;
      for (k = 0; k < 256; k++) used[k] = 1'b0;
      for (k = 0; k < itrs_pkg::NUM_SYMBOLS; k++) begin
         do b = $urandom_range(255);
         while (used[b] || b == itrs_pkg::PLUS_SYM || b == itrs_pkg::MINUS_SYM);
         used[b] = 1'b1;
         syms[k*8 +: 8] = b[7:0];
      end
      return syms;
   endfunction

   // The length register gets random upper bits, which the block must ignore.
   task automatic apply_alphabet(input logic [itrs_pkg::LEN_W-1:0] len,
                                 input logic [itrs_pkg::SYMS_W-1:0] syms);
      logic [itrs_pkg::CSR_DATA_W-1:0] d;
      d = {$urandom, $urandom};
      d[itrs_pkg::LEN_W-1:0] = len;
      write_csr(itrs_pkg::CSR_ALPHABET_LENGTH, d);
      write_csr(itrs_pkg::CSR_SYMBOLS_LOW, syms[63:0]);
      write_csr(itrs_pkg::CSR_SYMBOLS_HIGH, syms[127:64]);
   endtask

   // This function mixes full-width noise with small numbers and the values on either side
   // of zero and of the signed limits.
   function automatic logic [itrs_pkg::VALUE_W-1:0] pick_value();
      int roll;
      roll = $urandom_range(99);
      if (roll < 40) return $urandom;
      if (roll < 55) return $urandom | 32'h8000_0000;
      if (roll < 75) return 32'($signed($urandom_range(0, 40)) - 20);
      if (roll < 85) return 32'd1 << $urandom_range(0, 31);
      case ($urandom_range(0, 4))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'h8000_0001;
         3: return 32'hFFFF_FFFF;
         default: return 32'h0;
      endcase
   endfunction

   // Each random phase runs three valid alphabets. It ends with one broken alphabet,
   // whose requests must produce no text at all.
   task automatic run_phase(input int idle_pct, input int stall_pct, input int count);
      logic [itrs_pkg::SYMS_W-1:0] syms;
      logic [itrs_pkg::LEN_W-1:0]  len;
      int                          k;
      int                          m;
      int                          a;
      int                          b;
      flaw_type                    flaw;
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      for (k = 0; k < 3; k++) begin
         len = LEN_W'($urandom_range(2, itrs_pkg::MAX_RADIX_DEF));
         apply_alphabet(len, random_glyphs());
         for (m = 0; m < count / 3; m++) send_value(pick_value(), 1'b0, "");
      end
      syms = random_glyphs();
      len  = LEN_W'($urandom_range(2, itrs_pkg::MAX_RADIX_DEF));
      flaw = flaw_type'($urandom_range(0, 3));
      case (flaw)
         FLAW_LENGTH: begin
            len = LEN_W'($urandom_range(0, 1) ? $urandom_range(0, 1)
                                              : $urandom_range(17, 31));
         end
         FLAW_MINUS:  syms[$urandom_range(0, len - 1)*8 +: 8] = itrs_pkg::MINUS_SYM;
         FLAW_PLUS:   syms[$urandom_range(0, len - 1)*8 +: 8] = itrs_pkg::PLUS_SYM;
         FLAW_REPEAT: begin
            a = $urandom_range(0, len - 2);
            b = $urandom_range(a + 1, len - 1);
            syms[b*8 +: 8] = syms[a*8 +: 8];
         end
         default: ;
      endcase
      apply_alphabet(len, syms);
      for (m = 0; m < 2; m++) send_value(pick_value(), 1'b0, "");
   endtask

   // The receiver stalls at random in proportion to the current phase setting. When the
   // sender asks for a hold-off, the receiver counts out a long stretch with ready low.
   always @(posedge clock) begin
      if (hold_asked != hold_seen) begin
         hold_seen = hold_asked;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Every accepted character is checked against the oldest one still owed.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         glyphs_checked++;
         if (symbols_due.size() == 0) begin
            $display("%0t ns: unexpected symbol, expected none, got symbol %h final %b",
                     $time, rsp_symbol, rsp_final_symbol);
            mismatches++;
         end else begin
            glyph_want = symbols_due.pop_front();
            if (rsp_symbol !== glyph_want.glyph) begin
               $display("%0t ns: symbol mismatch, expected %h, got %h",
                        $time, glyph_want.glyph, rsp_symbol);
               mismatches++;
            end
            if (rsp_final_symbol !== glyph_want.last) begin
               $display("%0t ns: final flag mismatch, expected %b, got %b",
                        $time, glyph_want.last, rsp_final_symbol);
               mismatches++;
            end
         end
      end
   end

   initial begin
      #(TIMEOUT_NS);
      $display("[int_to_radix_symbols_core] ERROR");
      $finish;
   end

   initial begin
      int k;
      logic [itrs_pkg::SYMS_W-1:0] syms;

      // Right after reset the alphabet is empty, so nothing may come out.
      plan_value(32'h0000_0000, 1'b1, "");
      plan_value(32'h8000_0000, 1'b1, "");
      // For decimal, the signed limits and the values next to zero are easy to read.
      plan_csr(itrs_pkg::CSR_ALPHABET_LENGTH, 64'd10);
      plan_csr(itrs_pkg::CSR_SYMBOLS_LOW, 64'h3736_3534_3332_3130);
      plan_csr(itrs_pkg::CSR_SYMBOLS_HIGH, 64'h4645_4443_4241_3938);
      plan_value(32'h0000_0000, 1'b1, "0");
      plan_value(32'hFFFF_FFFF, 1'b1, "-1");
      plan_value(32'h7FFF_FFFF, 1'b1, "2147483647");
      plan_value(32'h8000_0000, 1'b1, "-2147483648");
      plan_value(32'h0000_0009, 1'b1, "9");
      // Hexadecimal uses the full sixteen-symbol alphabet.
      plan_csr(itrs_pkg::CSR_ALPHABET_LENGTH, 64'd16);
      plan_value(32'hFFFF_FFFF, 1'b1, "-1");
      plan_value(32'h8000_0000, 1'b1, "-80000000");
      plan_value(32'h7FFF_FFFF, 1'b1, "7FFFFFFF");
      plan_value(32'h1234_ABCD, 1'b1, "1234ABCD");
      // Binary gives the longest text, a sign plus 32 digits for the most negative value.
      plan_csr(itrs_pkg::CSR_ALPHABET_LENGTH, 64'd2);
      plan_value(32'h8000_0000, 1'b0, "");
      plan_value(32'h7FFF_FFFF, 1'b0, "");
      plan_value(32'h0000_0005, 1'b1, "101");
      // A write to the unmapped index must leave the radix at 2.
      plan_csr(CSR_UNMAPPED, 64'd10);
      plan_value(32'hFFFF_FFFE, 1'b1, "-10");
      // Only the low five bits of the length write count, so this sets radix 3.
      plan_csr(itrs_pkg::CSR_ALPHABET_LENGTH, 64'hFFFF_FFFF_FFFF_FFE3);
      plan_value(32'd100, 1'b0, "");
      // Lengths outside 2 to 16 are rejected.
      plan_csr(itrs_pkg::CSR_ALPHABET_LENGTH, 64'd17);
      plan_value(32'd1, 1'b1, "");
      plan_csr(itrs_pkg::CSR_ALPHABET_LENGTH, 64'd1);
      plan_value(32'd0, 1'b1, "");
      // A minus sign in the alphabet is rejected.
      plan_csr(itrs_pkg::CSR_ALPHABET_LENGTH, 64'd16);
      plan_csr(itrs_pkg::CSR_SYMBOLS_LOW, 64'h3736_2D34_3332_3130);
      plan_value(32'd7, 1'b1, "");
      // A plus sign in the alphabet is rejected too.
      plan_csr(itrs_pkg::CSR_SYMBOLS_LOW, 64'h3736_3534_3332_3130);
      plan_csr(itrs_pkg::CSR_SYMBOLS_HIGH, 64'h4645_4443_4241_392B);
      plan_value(32'd1, 1'b1, "");
      // A repeated symbol is rejected.
      plan_csr(itrs_pkg::CSR_SYMBOLS_HIGH, 64'h4645_4443_4241_3930);
      plan_value(32'd1, 1'b1, "");
      // Bytes past the length are not checked, so radix 8 works with the repeat above it.
      plan_csr(itrs_pkg::CSR_ALPHABET_LENGTH, 64'd8);
      plan_value(32'd8, 1'b1, "10");
      // A zero byte and an all-ones byte are ordinary symbols.
      plan_csr(itrs_pkg::CSR_ALPHABET_LENGTH, 64'd16);
      plan_csr(itrs_pkg::CSR_SYMBOLS_LOW, 64'h807F_55AA_01FE_FF00);
      plan_csr(itrs_pkg::CSR_SYMBOLS_HIGH, 64'hF0E1_D2C3_B4A5_9687);
      plan_value(32'h8000_0000, 1'b0, "");
      plan_value(32'h0000_0000, 1'b0, "");
      plan_value(32'h7EDC_BA98, 1'b0, "");

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (k = 0; k < plan.size(); k++) begin
         if (plan[k].kind == ROW_CSR) write_csr(plan[k].idx, plan[k].data);
         else send_value(plan[k].value, plan[k].typed, plan_text[k]);
      end

      // In the random phases, idle pressure moves from neither side to each side and
      // then to both.
      run_phase(0, 0, 21);
      run_phase(78, 0, 21);
      run_phase(0, 78, 21);
      run_phase(23, 23, 21);

      // The receiver holds off for a long stretch while requests keep coming back to back.
      // This backs the block up until its request channel has to stall.
      syms = random_glyphs();
      apply_alphabet(5'd10, syms);
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_asked++;
      for (k = 0; k < 12; k++) send_value(pick_value(), 1'b0, "");

      req_valid <= 1'b0;
      while (symbols_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Converted %0d requests into %0d checked characters across %0d register writes,",
               values_sent, glyphs_checked, csr_writes);
      $display("with valid and broken alphabets, radix 2 to 16, and all idle and stall mixes.");
      if (mismatches == 0 && symbols_due.size() == 0) begin
         $display("[int_to_radix_symbols_core] OK");
      end else begin
         $display("[int_to_radix_symbols_core] ERROR");
      end
      $finish;
   end

endmodule
